/* design/idsc_pkg.sv */
// idsc_pkg: field widths, walk-unit status type and calendar lookup functions
// for the inclusive date span counter; no dependencies
`default_nettype none

package idsc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  // absolute day numbers up to 16383 * 366 need 23 bits
  localparam int unsigned ACC_W   = 23;
  localparam int unsigned C100_W  = 7;
  localparam int unsigned C400_W  = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [8:0]         DAYS_YEAR = 9'd365;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic [ACC_W-1:0]  acc;
  } walk_t;

  // days in all months before month m of one year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m,
                                             input logic leap);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && m > 4'd2 && m < 4'd13) n = n + 9'd1;
    return n;
  endfunction

  // month length, zero for a month code that names no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:    n = leap ? 5'd29 : 5'd28;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* design/idsc_year_walk.sv */
// idsc_year_walk: shared year stepping unit, keeps the current year, its
// residues mod 100 and 400, and the days of all years before it; uses idsc_pkg
`default_nettype none

module idsc_year_walk (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic          step_i,
  output idsc_pkg::walk_t    walk_o
);
  import idsc_pkg::*;

  logic [YEAR_W-1:0] year_q, year_d;
  logic [C100_W-1:0] c100_q, c100_d;
  logic [C400_W-1:0] c400_q, c400_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              leap;

  assign leap = (c400_q == '0) || ((year_q[1:0] == 2'b00) && (c100_q != '0));

  always_comb begin
    year_d = year_q;
    c100_d = c100_q;
    c400_d = c400_q;
    acc_d  = acc_q;
    if (clear_i) begin
      // walk starts at year one with nothing before it
      year_d = YEAR_W'(1);
      c100_d = C100_W'(1);
      c400_d = C400_W'(1);
      acc_d  = '0;
    end else if (step_i) begin
      year_d = year_q + YEAR_W'(1);
      c100_d = (c100_q == C100_W'(99))  ? '0 : c100_q + C100_W'(1);
      c400_d = (c400_q == C400_W'(399)) ? '0 : c400_q + C400_W'(1);
      acc_d  = acc_q + ACC_W'(DAYS_YEAR) + ACC_W'(leap);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= YEAR_W'(1);
      c100_q <= C100_W'(1);
      c400_q <= C400_W'(1);
      acc_q  <= '0;
    end else begin
      year_q <= year_d;
      c100_q <= c100_d;
      c400_q <= c400_d;
      acc_q  <= acc_d;
    end
  end

  assign walk_o = {year_q, leap, acc_q};

endmodule

`default_nettype wire

/* design/inclusive_date_span_counter.sv */
// an accepted beat clears the year walk, which steps from year one up to the later
// year, then the result loads once the output is free; when either year is out of
// range the beat goes straight to the result. One request at a time: the next beat
// can be taken in the cycle after the result loads; a new beat is taken as soon as
// the walk is free, also while a result waits
// reset: asynchronous active-low, block idle with no result pending
`default_nettype none

module inclusive_date_span_counter #(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [idsc_pkg::YEAR_W-1:0]   first_year_i,
  input  wire logic [idsc_pkg::MONTH_W-1:0]  first_month_i,
  input  wire logic [idsc_pkg::DAY_W-1:0]    first_day_i,
  input  wire logic [idsc_pkg::YEAR_W-1:0]   last_year_i,
  input  wire logic [idsc_pkg::MONTH_W-1:0]  last_month_i,
  input  wire logic [idsc_pkg::DAY_W-1:0]    last_day_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [idsc_pkg::COUNT_W-1:0]       day_count_o,
  output logic                               bad_input_o
);
  import idsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  logic [YEAR_W-1:0]  sy_q, ey_q, ymax_q;
  logic [MONTH_W-1:0] sm_q, em_q;
  logic [DAY_W-1:0]   sd_q, ed_q;
  logic [ACC_W-1:0]   a_q, b_q;
  logic               s_ok_q, e_ok_q;

  logic               out_valid_q;
  logic [COUNT_W-1:0] count_q;
  logic               bad_q;

  logic    in_acc, out_free, walk_clear, walk_step;
  logic    s_yr_ok, e_yr_ok;
  walk_t   walk;
  logic [ACC_W:0]   diff;
  logic [ACC_W-1:0] span;

  idsc_year_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (walk_clear),
    .step_i  (walk_step),
    .walk_o  (walk)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign s_yr_ok = (first_year_i != '0) && (32'(first_year_i) <= YEAR_MAX);
  assign e_yr_ok = (last_year_i != '0) && (32'(last_year_i) <= YEAR_MAX);

  assign walk_clear = in_acc;
  assign walk_step  = (state_q == ST_WALK) && (walk.year != ymax_q);

  // end day number minus start day number; top bit set when end < start
  assign diff = {1'b0, b_q} - {1'b0, a_q};
  assign span = diff[ACC_W-1:0] + ACC_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = (s_yr_ok && e_yr_ok) ? ST_WALK : ST_DONE;
      ST_WALK: if (walk.year == ymax_q) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)              out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sy_q   <= first_year_i;
      sm_q   <= first_month_i;
      sd_q   <= first_day_i;
      ey_q   <= last_year_i;
      em_q   <= last_month_i;
      ed_q   <= last_day_i;
      ymax_q <= (first_year_i > last_year_i) ? first_year_i : last_year_i;
      s_ok_q <= 1'b0;
      e_ok_q <= 1'b0;
    end else if (state_q == ST_WALK) begin
      // capture each date as the walk passes its year
      if (walk.year == sy_q) begin
        a_q    <= walk.acc + ACC_W'(days_before(sm_q, walk.leap)) + ACC_W'(sd_q);
        s_ok_q <= (sd_q != '0) && (sd_q <= month_len(sm_q, walk.leap));
      end
      if (walk.year == ey_q) begin
        b_q    <= walk.acc + ACC_W'(days_before(em_q, walk.leap)) + ACC_W'(ed_q);
        e_ok_q <= (ed_q != '0) && (ed_q <= month_len(em_q, walk.leap));
      end
    end
    if (state_q == ST_DONE && out_free) begin
      if (!s_ok_q || !e_ok_q || diff[ACC_W]) begin
        count_q <= '0;
        bad_q   <= 1'b1;
      end else begin
        count_q <= (span > ACC_W'(COUNT_MAX)) ? COUNT_MAX : span[COUNT_W-1:0];
        bad_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_count_o = count_q;
  assign bad_input_o = bad_q;

  // walk never runs past the later year
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (walk.year <= ymax_q))
    else $error("year walk passed its end year");

  // a flagged result carries a zero count, a good one a nonzero count
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bad_input_o == (day_count_o == '0)))
    else $error("count and flag disagree");

  // result register only loads when the previous beat has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(count_q) && $stable(bad_q)))
    else $error("pending result overwritten");

  // input is only taken when the walk is free
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_WALK || state_q == ST_DONE))
    else $error("accepted beat did not start a request");

endmodule

`default_nettype wire
